>>> src/ncrf_pkg.sv
// Package of types, constants and helpers for the cubic Newton root finder.
package ncrf_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int TolWidth  = 31;
  localparam int IterWidth = 10;
  localparam int CfgIdxWidth = 3;
  localparam int QuoWidth  = DataWidth + FracBits;

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic [IterWidth-1:0] iter_t;
  typedef logic [TolWidth-1:0] tol_t;

  typedef enum logic [1:0] {
    STAT_CONVERGED = 2'd0,
    STAT_ZERO_DERIV = 2'd1,
    STAT_LIMIT = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_COEF_CUBIC = 3'd0,
    REG_COEF_SQUARE = 3'd1,
    REG_COEF_LINEAR_SUB = 3'd2,
    REG_COEF_CONST = 3'd3,
    REG_TOLERANCE = 3'd4,
    REG_MAX_ITERATIONS = 3'd5
  } reg_idx_t;

  // Sequencer states; each evaluation step uses the one multiplier or adder.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_X2,
    ST_X3,
    ST_AX3,
    ST_BX2,
    ST_CX0,
    ST_AX2,
    ST_BX0,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_D1,
    ST_D2,
    ST_D3,
    ST_D4,
    ST_D5,
    ST_CHECK,
    ST_DIV,
    ST_NEWX,
    ST_STEP,
    ST_DECIDE
  } state_t;

  localparam data_t VMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam data_t VMin = {1'b1, {(DataWidth-1){1'b0}}};

  // Saturating sum of two signed values; flag set on clamp.
  function automatic logic [DataWidth:0] sat_add(input data_t a, input data_t b);
    logic signed [DataWidth:0] s;
    data_t r;
    logic o;
    s = {a[DataWidth-1], a} + {b[DataWidth-1], b};
    o = (s[DataWidth] != s[DataWidth-1]);
    r = o ? (s[DataWidth] ? VMin : VMax) : s[DataWidth-1:0];
    return {o, r};
  endfunction

  // Absolute value, with the most negative number clamped to the largest.
  function automatic logic [DataWidth-1:0] sat_abs(input data_t a);
    logic [DataWidth-1:0] r;
    r = a[DataWidth-1] ? ((a == VMin) ? VMax : DataWidth'(-a)) : a;
    return r;
  endfunction

endpackage

>>> src/newton_cubic_root_finder.sv
// Top level of the cubic Newton root finder with its shared datapath and sequencer.
//
// Usage: program the coefficients a, b, c, d (signed Q16.16), the tolerance and
// the iteration limit through the cfg_ write port while the block is idle.
// Then pulse start with in_start_x, the starting guess, while busy is low.
// The block runs Newton steps on f(x) = a*x^3 + b*x^2 - c*x + d, one step being
// seven products through one 32x32 multiplier, a chain of saturating adds
// through one adder, and a restoring divide that produces one
// quotient bit a cycle. The default iteration limit is 100.
// When done, out_valid is high for one cycle with the root, the last step, the
// iteration count and the status word. busy stays high from the accepted start
// until that cycle; start is ignored while busy. The receiver cannot stall, so
// the result word must be taken in its cycle. Synchronous active-low reset
// returns the sequencer to idle and the registers to their reset values:
// zero coefficients, tolerance 66 and an iteration limit of 100.
module newton_cubic_root_finder (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [ncrf_pkg::DataWidth-1:0]  in_start_x,
  input  logic                                   cfg_we,
  input  logic [ncrf_pkg::CfgIdxWidth-1:0]       cfg_index,
  input  logic [ncrf_pkg::DataWidth-1:0]         cfg_data,
  output logic                                   out_valid,
  output logic signed [ncrf_pkg::DataWidth-1:0]  out_root,
  output logic signed [ncrf_pkg::DataWidth-1:0]  out_last_step,
  output logic [ncrf_pkg::IterWidth-1:0]         out_iteration_count,
  output logic [1:0]                             out_status
);

  localparam int DW = ncrf_pkg::DataWidth;
  localparam int FB = ncrf_pkg::FracBits;
  localparam int QW = ncrf_pkg::QuoWidth;
  localparam int CW = $clog2(QW + 1);

  // Configuration registers.
  ncrf_pkg::data_t coef_a_r, coef_b_r, coef_c_r, coef_d_r;
  ncrf_pkg::tol_t  tol_r;
  ncrf_pkg::iter_t max_it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= '0;
      coef_b_r <= '0;
      coef_c_r <= '0;
      coef_d_r <= '0;
      tol_r    <= ncrf_pkg::TolWidth'(66);
      max_it_r <= ncrf_pkg::IterWidth'(100);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ncrf_pkg::REG_COEF_CUBIC:      coef_a_r <= cfg_data;
        ncrf_pkg::REG_COEF_SQUARE:     coef_b_r <= cfg_data;
        ncrf_pkg::REG_COEF_LINEAR_SUB: coef_c_r <= cfg_data;
        ncrf_pkg::REG_COEF_CONST:      coef_d_r <= cfg_data;
        ncrf_pkg::REG_TOLERANCE:       tol_r    <= cfg_data[ncrf_pkg::TolWidth-1:0];
        ncrf_pkg::REG_MAX_ITERATIONS:  max_it_r <= cfg_data[ncrf_pkg::IterWidth-1:0];
        default: ;
      endcase
    end
  end

  // Working registers.
  ncrf_pkg::state_t state_r, state_nxt;
  ncrf_pkg::data_t x0_r, x0_nxt, xn_r, xn_nxt, x2_r, x2_nxt, x3_r, x3_nxt;
  ncrf_pkg::data_t p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt;
  ncrf_pkg::data_t t_r, t_nxt, bx0_r, bx0_nxt, f_r, f_nxt, fd_r, fd_nxt;
  ncrf_pkg::data_t acc_r, acc_nxt, step_r, step_nxt;
  ncrf_pkg::iter_t k_r, k_nxt;
  logic ovf_r, ovf_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] status_r, status_nxt;

  // Divider state: restoring, one quotient bit per cycle.
  logic [QW-1:0] num_r, num_nxt, quo_r, quo_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic          qneg_r, qneg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Shared multiplier: sign-magnitude, shift by FracBits, saturate.
  ncrf_pkg::data_t mul_a, mul_b;
  logic [DW-1:0]   mag_a, mag_b;
  logic [2*DW-1:0] prod;
  logic [2*DW-FB-1:0] prod_sh;
  logic            mul_neg, mul_ovf;
  ncrf_pkg::data_t mul_res;

  always_comb begin
    mag_a   = mul_a[DW-1] ? DW'(-mul_a) : mul_a;
    mag_b   = mul_b[DW-1] ? DW'(-mul_b) : mul_b;
    prod    = mag_a * mag_b;
    prod_sh = prod[2*DW-1:FB];
    mul_neg = mul_a[DW-1] ^ mul_b[DW-1];
    if (mul_neg) begin
      mul_ovf = (prod_sh > (2*DW-FB)'({1'b1, {(DW-1){1'b0}}}));
      mul_res = mul_ovf ? ncrf_pkg::VMin : DW'(-prod_sh[DW-1:0]);
    end else begin
      mul_ovf = (prod_sh > (2*DW-FB)'(ncrf_pkg::VMax));
      mul_res = mul_ovf ? ncrf_pkg::VMax : prod_sh[DW-1:0];
    end
  end

  // Shared saturating adder.
  ncrf_pkg::data_t add_a, add_b, add_res;
  logic add_ovf;
  assign {add_ovf, add_res} = ncrf_pkg::sat_add(add_a, add_b);

  // Divider trial subtract.
  logic [DW:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem_r[DW-1:0], num_r[QW-1]};
  assign rem_ge = (rem_sh >= {1'b0, den_r});

  // Quotient magnitude to signed saturated value.
  logic            q_ovf;
  ncrf_pkg::data_t q_res;
  always_comb begin
    if (qneg_r) begin
      q_ovf = (quo_r > QW'({1'b1, {(DW-1){1'b0}}}));
      q_res = q_ovf ? ncrf_pkg::VMin : DW'(-quo_r[DW-1:0]);
    end else begin
      q_ovf = (quo_r > QW'(ncrf_pkg::VMax));
      q_res = q_ovf ? ncrf_pkg::VMax : quo_r[DW-1:0];
    end
  end

  logic conv;
  assign conv = (ncrf_pkg::sat_abs(step_r) < {1'b0, tol_r}) &&
                (ncrf_pkg::sat_abs(f_r) < {1'b0, tol_r});

  always_comb begin
    state_nxt = state_r;
    x0_nxt = x0_r; xn_nxt = xn_r; x2_nxt = x2_r; x3_nxt = x3_r;
    p1_nxt = p1_r; p2_nxt = p2_r; p3_nxt = p3_r; t_nxt = t_r;
    bx0_nxt = bx0_r; f_nxt = f_r; fd_nxt = fd_r; acc_nxt = acc_r;
    step_nxt = step_r; k_nxt = k_r; ovf_nxt = ovf_r;
    status_nxt = status_r; out_valid_nxt = 1'b0;
    num_nxt = num_r; quo_nxt = quo_r; rem_nxt = rem_r; den_nxt = den_r;
    qneg_nxt = qneg_r; cnt_nxt = cnt_r;
    mul_a = x0_r; mul_b = x0_r;
    add_a = acc_r; add_b = acc_r;

    unique case (state_r)
      // The result cycle still counts as busy, so a start there waits.
      ncrf_pkg::ST_IDLE: begin
        if (start && !busy) begin
          xn_nxt = in_start_x;
          x0_nxt = in_start_x;
          k_nxt = '0;
          ovf_nxt = 1'b0;
          state_nxt = ncrf_pkg::ST_X2;
        end
      end
      ncrf_pkg::ST_X2: begin
        x0_nxt = xn_r;
        mul_a = xn_r; mul_b = xn_r;
        x2_nxt = mul_res; ovf_nxt = ovf_r | mul_ovf;
        state_nxt = ncrf_pkg::ST_X3;
      end
      ncrf_pkg::ST_X3: begin
        mul_a = x2_r; mul_b = x0_r;
        x3_nxt = mul_res; ovf_nxt = ovf_r | mul_ovf;
        state_nxt = ncrf_pkg::ST_AX3;
      end
      ncrf_pkg::ST_AX3: begin
        mul_a = coef_a_r; mul_b = x3_r;
        p1_nxt = mul_res; ovf_nxt = ovf_r | mul_ovf;
        state_nxt = ncrf_pkg::ST_BX2;
      end
      ncrf_pkg::ST_BX2: begin
        mul_a = coef_b_r; mul_b = x2_r;
        p2_nxt = mul_res; ovf_nxt = ovf_r | mul_ovf;
        state_nxt = ncrf_pkg::ST_CX0;
      end
      ncrf_pkg::ST_CX0: begin
        mul_a = coef_c_r; mul_b = x0_r;
        p3_nxt = mul_res; ovf_nxt = ovf_r | mul_ovf;
        state_nxt = ncrf_pkg::ST_AX2;
      end
      ncrf_pkg::ST_AX2: begin
        mul_a = coef_a_r; mul_b = x2_r;
        t_nxt = mul_res; ovf_nxt = ovf_r | mul_ovf;
        state_nxt = ncrf_pkg::ST_BX0;
      end
      ncrf_pkg::ST_BX0: begin
        mul_a = coef_b_r; mul_b = x0_r;
        bx0_nxt = mul_res; ovf_nxt = ovf_r | mul_ovf;
        state_nxt = ncrf_pkg::ST_F1;
      end
      // f = a*x3 + ((b*x2 - c*x0) + d). The subtraction saturates as a-b;
      // negating p3 would mis-saturate at the most negative value, so that
      // case of p3 is handled apart below.
      ncrf_pkg::ST_F1: begin
        add_a = p2_r; add_b = DW'(-p3_r);
        if (p3_r == ncrf_pkg::VMin) begin
          acc_nxt = p2_r[DW-1] ? DW'(p2_r - p3_r) : ncrf_pkg::VMax;
          ovf_nxt = ovf_r | ~p2_r[DW-1];
        end else begin
          acc_nxt = add_res; ovf_nxt = ovf_r | add_ovf;
        end
        state_nxt = ncrf_pkg::ST_F2;
      end
      ncrf_pkg::ST_F2: begin
        add_a = acc_r; add_b = coef_d_r;
        acc_nxt = add_res; ovf_nxt = ovf_r | add_ovf;
        state_nxt = ncrf_pkg::ST_F3;
      end
      ncrf_pkg::ST_F3: begin
        add_a = p1_r; add_b = acc_r;
        f_nxt = add_res; ovf_nxt = ovf_r | add_ovf;
        state_nxt = ncrf_pkg::ST_D1;
      end
      ncrf_pkg::ST_D1: begin
        add_a = t_r; add_b = t_r;
        acc_nxt = add_res; ovf_nxt = ovf_r | add_ovf;
        state_nxt = ncrf_pkg::ST_D2;
      end
      ncrf_pkg::ST_D2: begin
        add_a = acc_r; add_b = t_r;
        acc_nxt = add_res; ovf_nxt = ovf_r | add_ovf;
        state_nxt = ncrf_pkg::ST_D3;
      end
      ncrf_pkg::ST_D3: begin
        add_a = bx0_r; add_b = bx0_r;
        p1_nxt = add_res; ovf_nxt = ovf_r | add_ovf;
        state_nxt = ncrf_pkg::ST_D4;
      end
      ncrf_pkg::ST_D4: begin
        add_a = acc_r; add_b = p1_r;
        acc_nxt = add_res; ovf_nxt = ovf_r | add_ovf;
        state_nxt = ncrf_pkg::ST_D5;
      end
      ncrf_pkg::ST_D5: begin
        add_a = acc_r; add_b = DW'(-coef_c_r);
        if (coef_c_r == ncrf_pkg::VMin) begin
          fd_nxt = acc_r[DW-1] ? DW'(acc_r - coef_c_r) : ncrf_pkg::VMax;
          ovf_nxt = ovf_r | ~acc_r[DW-1];
        end else begin
          fd_nxt = add_res; ovf_nxt = ovf_r | add_ovf;
        end
        k_nxt = k_r + 1'b1;
        state_nxt = ncrf_pkg::ST_CHECK;
      end
      ncrf_pkg::ST_CHECK: begin
        if (fd_r == '0) begin
          xn_nxt = x0_r;
          step_nxt = '0;
          status_nxt = ncrf_pkg::STAT_ZERO_DERIV;
          out_valid_nxt = 1'b1;
          state_nxt = ncrf_pkg::ST_IDLE;
        end else begin
          num_nxt = {(f_r[DW-1] ? DW'(-f_r) : f_r), {FB{1'b0}}};
          den_nxt = fd_r[DW-1] ? DW'(-fd_r) : fd_r;
          qneg_nxt = f_r[DW-1] ^ fd_r[DW-1];
          rem_nxt = '0;
          quo_nxt = '0;
          cnt_nxt = CW'(QW);
          state_nxt = ncrf_pkg::ST_DIV;
        end
      end
      ncrf_pkg::ST_DIV: begin
        rem_nxt = rem_ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
        quo_nxt = {quo_r[QW-2:0], rem_ge};
        num_nxt = {num_r[QW-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = ncrf_pkg::ST_NEWX;
        end
      end
      // xn = x0 - q, done as x0 + (-q) with the most negative q handled apart.
      ncrf_pkg::ST_NEWX: begin
        add_a = x0_r; add_b = DW'(-q_res);
        if (q_res == ncrf_pkg::VMin) begin
          xn_nxt = x0_r[DW-1] ? DW'(x0_r - q_res) : ncrf_pkg::VMax;
          ovf_nxt = ovf_r | q_ovf | ~x0_r[DW-1];
        end else begin
          xn_nxt = add_res; ovf_nxt = ovf_r | q_ovf | add_ovf;
        end
        state_nxt = ncrf_pkg::ST_STEP;
      end
      ncrf_pkg::ST_STEP: begin
        add_a = xn_r; add_b = DW'(-x0_r);
        if (x0_r == ncrf_pkg::VMin) begin
          step_nxt = xn_r[DW-1] ? DW'(xn_r - x0_r) : ncrf_pkg::VMax;
          ovf_nxt = ovf_r | ~xn_r[DW-1];
        end else begin
          step_nxt = add_res; ovf_nxt = ovf_r | add_ovf;
        end
        state_nxt = ncrf_pkg::ST_DECIDE;
      end
      ncrf_pkg::ST_DECIDE: begin
        if (conv) begin
          status_nxt = ovf_r ? ncrf_pkg::STAT_OVERFLOW : ncrf_pkg::STAT_CONVERGED;
          out_valid_nxt = 1'b1;
          state_nxt = ncrf_pkg::ST_IDLE;
        end else if (k_r >= max_it_r) begin
          status_nxt = ovf_r ? ncrf_pkg::STAT_OVERFLOW : ncrf_pkg::STAT_LIMIT;
          out_valid_nxt = 1'b1;
          state_nxt = ncrf_pkg::ST_IDLE;
        end else begin
          state_nxt = ncrf_pkg::ST_X2;
        end
      end
      default: state_nxt = ncrf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ncrf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x0_r <= x0_nxt; xn_r <= xn_nxt; x2_r <= x2_nxt; x3_r <= x3_nxt;
    p1_r <= p1_nxt; p2_r <= p2_nxt; p3_r <= p3_nxt; t_r <= t_nxt;
    bx0_r <= bx0_nxt; f_r <= f_nxt; fd_r <= fd_nxt; acc_r <= acc_nxt;
    step_r <= step_nxt; k_r <= k_nxt; ovf_r <= ovf_nxt; status_r <= status_nxt;
    num_r <= num_nxt; quo_r <= quo_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
    qneg_r <= qneg_nxt; cnt_r <= cnt_nxt;
  end

  // The result word sits on the ports while out_valid is high.
  assign busy                = (state_r != ncrf_pkg::ST_IDLE) || out_valid_r;
  assign out_valid           = out_valid_r;
  assign out_root            = xn_r;
  assign out_last_step       = step_r;
  assign out_iteration_count = k_r;
  assign out_status          = status_r;

  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe while not busy");
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_iteration_count != '0)) else $error("result with no iteration");
  a_zero_deriv_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ncrf_pkg::STAT_ZERO_DERIV) |-> (out_last_step == '0))
    else $error("zero-derivative result with nonzero step");

endmodule

>>> sim/tb.sv
// Self-checking testbench for the cubic Newton root finder: directed table, then random phases.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One result word of the block: what the checker compares field by field.
  typedef struct {
    ncrf_pkg::data_t   root;
    ncrf_pkg::data_t   step;
    ncrf_pkg::iter_t   count;
    ncrf_pkg::status_t status;
  } root_word_t;

  // One row of the directed table. When write_cfg is set, all six registers
  // are written before the start point is sent. When typed is set, the
  // expected word is the one typed into the row rather than the predictor's.
  typedef struct {
    bit          write_cfg;
    logic [31:0] a, b, c, d, tol, iters;
    logic [31:0] x;
    bit          typed;
    logic [31:0] root, step;
    int          count;
    ncrf_pkg::status_t status;
  } row_t;

  localparam longint ValMax = 64'sd2147483647;
  localparam longint ValMin = -64'sd2147483648;
  localparam int WatchdogLimit = 300000;
  localparam int NumRows = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  ncrf_pkg::data_t in_start_x = '0;
  logic        cfg_we = 1'b0;
  logic [ncrf_pkg::CfgIdxWidth-1:0] cfg_index = '0;
  logic [ncrf_pkg::DataWidth-1:0]   cfg_data = '0;
  logic        out_valid;
  ncrf_pkg::data_t out_root;
  ncrf_pkg::data_t out_last_step;
  ncrf_pkg::iter_t out_iteration_count;
  logic [1:0]  out_status;

  newton_cubic_root_finder dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_start_x(in_start_x),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_root(out_root),
    .out_last_step(out_last_step),
    .out_iteration_count(out_iteration_count),
    .out_status(out_status)
  );

  // The testbench clock: 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Our copy of the configuration registers, kept in step with every write.
  longint coef_a = 0, coef_b = 0, coef_c = 0, coef_d = 0;
  longint tol_bound = 66;
  int     iter_limit = 100;
  bit     sat_seen;

  // Results still owed by the block, oldest first.
  root_word_t pending_roots[$];
  int mismatches = 0;
  int words_sent = 0;
  int words_seen = 0;
  int phases = 0;
  int status_hits[4] = '{0, 0, 0, 0};
  int idle_cycles = 0;

  // Saturating arithmetic on Q16.16 values held in 64-bit integers. Every
  // clamp raises sat_seen, which the solver turns into the overflow status.
  function automatic longint clamp32(longint v);
    if (v > ValMax) begin
      sat_seen = 1'b1;
      return ValMax;
    end
    if (v < ValMin) begin
      sat_seen = 1'b1;
      return ValMin;
    end
    return v;
  endfunction

  function automatic longint q_add(longint p, longint q);
    return clamp32(p + q);
  endfunction

  function automatic longint q_sub(longint p, longint q);
    return clamp32(p - q);
  endfunction

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // The exact product of two 32-bit values fits in 64 bits; the shift works
  // on the magnitude so that it truncates toward zero.
  function automatic longint q_mul(longint p, longint q);
    longint prod;
    longint m;
    prod = p * q;
    m = abs64(prod) >>> ncrf_pkg::FracBits;
    return clamp32((prod < 0) ? -m : m);
  endfunction

  // Quotient (p << FracBits) / q, truncated toward zero; q is never zero here.
  function automatic longint q_div(longint p, longint q);
    longint m;
    m = (abs64(p) << ncrf_pkg::FracBits) / abs64(q);
    return clamp32(((p < 0) != (q < 0)) ? -m : m);
  endfunction

  // Runs the whole Newton iteration for one start point under the current
  // configuration and returns the word the block should produce.
  function automatic root_word_t newton_solve(ncrf_pkg::data_t start_pt);
    root_word_t w;
    longint xn, x0, step, x2, x3, f, fd, t;
    int k;
    xn = longint'(start_pt);
    step = 0;
    k = 0;
    sat_seen = 1'b0;
    forever begin
      x0 = xn;
      x2 = q_mul(x0, x0);
      x3 = q_mul(x2, x0);
      f = q_add(q_mul(coef_a, x3),
                q_add(q_sub(q_mul(coef_b, x2), q_mul(coef_c, x0)), coef_d));
      t = q_mul(coef_a, x2);
      fd = q_mul(coef_b, x0);
      fd = q_sub(q_add(q_add(q_add(t, t), t), q_add(fd, fd)), coef_c);
      k++;
      if (fd == 0) begin
        xn = x0;
        step = 0;
        w.status = ncrf_pkg::STAT_ZERO_DERIV;
        break;
      end
      xn = q_sub(x0, q_div(f, fd));
      step = q_sub(xn, x0);
      if (abs64(step) < tol_bound && abs64(f) < tol_bound) begin
        w.status = sat_seen ? ncrf_pkg::STAT_OVERFLOW : ncrf_pkg::STAT_CONVERGED;
        break;
      end
      // A limit of zero behaves as one, since k is at least one here.
      if (k >= iter_limit) begin
        w.status = sat_seen ? ncrf_pkg::STAT_OVERFLOW : ncrf_pkg::STAT_LIMIT;
        break;
      end
    end
    w.root = ncrf_pkg::data_t'(xn);
    w.step = ncrf_pkg::data_t'(step);
    w.count = ncrf_pkg::iter_t'(k);
    return w;
  endfunction

  // Drives one register write for one cycle and mirrors it in our copy. The
  // caller drops the write enable after the last write. Called only while idle.
  task automatic write_reg(ncrf_pkg::reg_idx_t idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      ncrf_pkg::REG_COEF_CUBIC: coef_a = longint'($signed(value));
      ncrf_pkg::REG_COEF_SQUARE: coef_b = longint'($signed(value));
      ncrf_pkg::REG_COEF_LINEAR_SUB: coef_c = longint'($signed(value));
      ncrf_pkg::REG_COEF_CONST: coef_d = longint'($signed(value));
      ncrf_pkg::REG_TOLERANCE: tol_bound = longint'(value[ncrf_pkg::TolWidth-1:0]);
      ncrf_pkg::REG_MAX_ITERATIONS: iter_limit = int'(value[ncrf_pkg::IterWidth-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Waits until every owed result has come back, then programs a full setting.
  // Every item produces a result, so once the queue drains the block is idle;
  // the extra wait only keeps the write clear of the result cycle.
  task automatic program_all(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                             logic [31:0] d, logic [31:0] tol, logic [31:0] iters);
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_reg(ncrf_pkg::REG_COEF_CUBIC, a);
    write_reg(ncrf_pkg::REG_COEF_SQUARE, b);
    write_reg(ncrf_pkg::REG_COEF_LINEAR_SUB, c);
    write_reg(ncrf_pkg::REG_COEF_CONST, d);
    write_reg(ncrf_pkg::REG_TOLERANCE, tol);
    write_reg(ncrf_pkg::REG_MAX_ITERATIONS, iters);
    cfg_we <= 1'b0;
    phases++;
  endtask

  // Sends one start point after a gap, holding start until the block takes
  // it. Start always drops at the accepting edge and rises again at a later
  // one, so no step carries two assignments to it. The expected word is
  // queued in the accepting step, long before the block can answer.
  task automatic send_word(ncrf_pkg::data_t x, int gap, bit typed, root_word_t typed_word);
    repeat (gap + 1) @(posedge clk);
    start <= 1'b1;
    in_start_x <= x;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    pending_roots.push_back(typed ? typed_word : newton_solve(x));
    words_sent++;
  endtask

  // Gap before a word: mostly none, sometimes short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Coefficients are mostly small so that Newton has something to find, with
  // zeros and full-range values mixed in to hit the overflow paths.
  function automatic logic [31:0] pick_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) return 32'd0;
    return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
  endfunction

  function automatic ncrf_pkg::data_t pick_start();
    if ($urandom_range(0, 5) == 0) return ncrf_pkg::data_t'($urandom);
    return ncrf_pkg::data_t'(32'($urandom_range(0, 32'h100000)) - 32'h80000);
  endfunction

  // The directed table. The first rows run on the reset setting, where every
  // coefficient is zero and so the derivative is zero at once. The pure linear
  // rows (c = -1.0, so f(x) = x) are easy to work out by hand: one step lands
  // on zero and the second converges; zero tolerance runs to the limit; a
  // zero limit stops after one iteration. The remaining rows push the extreme
  // coefficients, the widest tolerance written with its unused top bit set,
  // and the largest iteration limit on a quadratic with no real root.
  row_t rows[NumRows] = '{
    '{1'b0, 0, 0, 0, 0, 0, 0, 32'h0001_2345,
      1'b1, 32'h0001_2345, 0, 1, ncrf_pkg::STAT_ZERO_DERIV},
    '{1'b0, 0, 0, 0, 0, 0, 0, 32'h8000_0000,
      1'b1, 32'h8000_0000, 0, 1, ncrf_pkg::STAT_ZERO_DERIV},
    '{1'b0, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff,
      1'b1, 32'h7fff_ffff, 0, 1, ncrf_pkg::STAT_ZERO_DERIV},
    '{1'b1, 0, 0, 32'hffff_0000, 0, 66, 100, 32'h0003_0000,
      1'b1, 0, 0, 2, ncrf_pkg::STAT_CONVERGED},
    '{1'b1, 0, 0, 32'hffff_0000, 0, 0, 5, 32'h0003_0000,
      1'b1, 0, 0, 5, ncrf_pkg::STAT_LIMIT},
    '{1'b1, 0, 0, 32'hffff_0000, 0, 66, 0, 32'h0003_0000,
      1'b1, 0, 32'hfffd_0000, 1, ncrf_pkg::STAT_LIMIT},
    '{1'b1, 32'h0001_0000, 0, 32'h0002_0000, 0, 66, 100, 32'h0001_8000,
      1'b0, 0, 0, 0, ncrf_pkg::STAT_CONVERGED},
    '{1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
      32'hffff_ffff, 100, 32'h0001_0000, 1'b0, 0, 0, 0, ncrf_pkg::STAT_CONVERGED},
    '{1'b0, 0, 0, 0, 0, 0, 0, 32'h8000_0000,
      1'b0, 0, 0, 0, ncrf_pkg::STAT_CONVERGED},
    '{1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
      66, 32'h3ff, 32'hffff_8000, 1'b0, 0, 0, 0, ncrf_pkg::STAT_CONVERGED},
    '{1'b1, 0, 32'h0001_0000, 0, 32'h0001_0000, 66, 32'h3ff, 32'h0000_8000,
      1'b0, 0, 0, 0, ncrf_pkg::STAT_CONVERGED},
    '{1'b1, 32'h0001_0000, 0, 0, 32'hfff8_0000, 1, 50, 32'h0001_0000,
      1'b0, 0, 0, 0, ncrf_pkg::STAT_CONVERGED}
  };

  // Stimulus: reset, the directed table, then random phases, each phase a
  // fresh setting followed by a burst of start points.
  initial begin
    root_word_t typed_word;
    logic [31:0] tol_word, iter_word;
    int burst;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].write_cfg) begin
        program_all(rows[i].a, rows[i].b, rows[i].c, rows[i].d,
                    rows[i].tol, rows[i].iters);
      end
      typed_word.root = rows[i].root;
      typed_word.step = rows[i].step;
      typed_word.count = ncrf_pkg::iter_t'(rows[i].count);
      typed_word.status = rows[i].status;
      send_word(rows[i].x, pick_gap(), rows[i].typed, typed_word);
    end

    while (words_sent < NumRows + 300) begin
      case ($urandom_range(0, 7))
        0: tol_word = 32'd0;
        1, 2: tol_word = $urandom;
        default: tol_word = $urandom_range(1, 32'h2000);
      endcase
      // Iteration limits stay small most of the time to keep the run short.
      case ($urandom_range(0, 9))
        0: iter_word = 32'd100;
        1: iter_word = {$urandom_range(0, 32'h3fffff), 10'd0};
        default: iter_word = $urandom_range(1, 30);
      endcase
      program_all(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                  tol_word, iter_word);
      burst = $urandom_range(5, 25);
      repeat (burst) send_word(pick_start(), pick_gap(), 1'b0, typed_word);
    end

    while (pending_roots.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d start points over %0d register settings; %0d results checked.",
             words_sent, phases, words_seen);
    $display("Status mix: %0d converged, %0d zero derivative, %0d limit, %0d overflow.",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
    if (mismatches == 0 && pending_roots.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result checker. The receiver cannot stall, so every cycle with out_valid
  // high is one result word, compared against the oldest expectation.
  always @(posedge clk) begin
    root_word_t want;
    if (rst_n && out_valid) begin
      words_seen++;
      status_hits[out_status]++;
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result word: root %h step %h count %0d status %0d",
                   out_root, out_last_step, out_iteration_count, out_status);
        end
      end else begin
        want = pending_roots.pop_front();
        if (out_root !== want.root || out_last_step !== want.step ||
            out_iteration_count !== want.count || out_status !== want.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch on word %0d: want root %h step %h count %0d status %0d",
                     words_seen, want.root, want.step, want.count, want.status);
            $display("                      got  root %h step %h count %0d status %0d",
                     out_root, out_last_step, out_iteration_count, out_status);
          end
        end
      end
    end
  end

  // Watchdog: the longest legal quiet stretch is one item at the largest
  // iteration limit, and WatchdogLimit is several times that stretch.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Timed out with %0d results outstanding.", pending_roots.size());
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> newton_cubic_root_finder.f
src/ncrf_pkg.sv
src/newton_cubic_root_finder.sv
sim/tb.sv
